FILE: design/rqbd_pkg.sv
// Shared types and codes for the ring queue with batch drop.
// No dependencies; the top level, controller and datapath refer to this package.
package rqbd_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 8;
  localparam int SLOTS_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [WORD_W-1:0]  push_value;
    logic [COUNT_W-1:0] remove_count;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] pop_value;
    logic              is_empty;
    logic              is_full;
  } out_item_t;

  typedef logic [SLOTS_W-1:0] cfg_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic exec;    // run the accepted item against the indices and memory
    logic load;    // move the finished result into the output register
    logic cfg_wr;  // take a new ring size and empty the queue
  } ctrl_cmd_t;

endpackage

FILE: design/rqbd_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
// Payload type is set through the type parameter.
interface rqbd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ring_queue_with_batch_drop.sv
// Top level of the ring queue with batch drop: controller plus datapath.
// Depends on rqbd_pkg, rqbd_chan_if, rqbd_ctrl and rqbd_dp.
//
//   Channel  Dir  Payload                                   Handshake
//   in_ch    in   operation, push_value, remove_count       valid/ready
//   out_ch   out  status, pop_value, is_empty, is_full      valid/ready
//   cfg_ch   in   slots_in_use (5 bits)                     valid/ready
//
// Sequence: an accepted item is first run against the indices and the slot
// memory; the registered memory read then reaches the output register once
// that register is free, and only after that load is the next item taken.
// Reset: rst_n is synchronous and active low; it sets the ring size to 16 and
// empties the queue. The slot memory is not cleared; no clearing pass.
// Stalls: a finished result waits in the output register while the next item
// is accepted; a second result holds in the datapath until the first is taken.
module ring_queue_with_batch_drop #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  rqbd_chan_if.sink   in_ch,
  rqbd_chan_if.source out_ch,
  rqbd_chan_if.sink   cfg_ch
);

  rqbd_pkg::ctrl_cmd_t cmd;

  // sequence the item: accept, run, load the result
  rqbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cmd       (cmd)
  );

  // hold the indices, ring size, slots and the result register
  rqbd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_ch.data),
    .cfg_word (cfg_ch.data),
    .out_item (out_ch.data)
  );

endmodule

FILE: design/rqbd_ctrl.sv
// Controller for the ring queue: sequences execute and result load, owns out valid.
// Depends on rqbd_pkg for the command struct.
module rqbd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output rqbd_pkg::ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    cfg_ready  = (state_r == S_IDLE);
    in_ready   = (state_r == S_IDLE) && !cfg_valid;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    cmd.exec   = in_valid && in_ready;
    cmd.load   = (state_r == S_LOAD) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.exec) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (cmd.load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/rqbd_dp.sv
// Datapath for the ring queue: indices, ring size, slot memory, result register.
// Depends on rqbd_pkg for item types and codes.
module rqbd_dp #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rqbd_pkg::ctrl_cmd_t   cmd,
  input  rqbd_pkg::in_item_t    in_item,
  input  rqbd_pkg::cfg_word_t   cfg_word,
  output rqbd_pkg::out_item_t   out_item
);

  localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = ((IW > rqbd_pkg::SLOTS_W) ? IW : rqbd_pkg::SLOTS_W) + 1;
  localparam int AW = ((CW > rqbd_pkg::COUNT_W) ? CW : rqbd_pkg::COUNT_W) + 1;

  logic [rqbd_pkg::WORD_W-1:0] mem [DEPTH];
  logic [rqbd_pkg::WORD_W-1:0] rdata_r;

  logic [rqbd_pkg::SLOTS_W-1:0] slots_r;
  logic [IW-1:0]                head_r, tail_r;
  logic [rqbd_pkg::STAT_W-1:0]  status_r;
  logic                         pop_ok_r, empty_r, full_r;
  rqbd_pkg::out_item_t          out_r;

  logic [CW-1:0] slots_x, size, head_e, tail_e, head_inc, tail_inc, fill;
  logic [CW-1:0] head_n, tail_n, tail_n_inc;
  logic [AW-1:0] head_add;
  logic          empty_now, full_now, push_ok, pop_ok;
  logic [rqbd_pkg::STAT_W-1:0] status_n;

  always_comb begin
    // clamp ring size to 2..DEPTH
    slots_x = CW'(slots_r);
    if (slots_x < CW'(2)) begin
      size = CW'(2);
    end else if (slots_x > CW'(DEPTH)) begin
      size = CW'(DEPTH);
    end else begin
      size = slots_x;
    end

    head_e = (CW'(head_r) >= size) ? '0 : CW'(head_r);
    tail_e = (CW'(tail_r) >= size) ? '0 : CW'(tail_r);

    head_inc = head_e + CW'(1);
    if (head_inc >= size) head_inc = head_inc - size;
    tail_inc = tail_e + CW'(1);
    if (tail_inc >= size) tail_inc = tail_inc - size;

    empty_now = (head_e == tail_e);
    full_now  = (tail_inc == head_e);

    fill = (head_e > tail_e) ? (tail_e + size - head_e) : (tail_e - head_e);

    // drop advances by at most the fill level, so one wrap suffices
    head_add = AW'(head_e) + AW'(in_item.remove_count);
    if (head_add >= AW'(size)) head_add = head_add - AW'(size);

    head_n   = head_e;
    tail_n   = tail_e;
    status_n = rqbd_pkg::ST_OK;
    push_ok  = 1'b0;
    pop_ok   = 1'b0;
    case (in_item.operation)
      rqbd_pkg::OP_PUSH: begin
        if (full_now) begin
          status_n = rqbd_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
          tail_n  = tail_inc;
        end
      end
      rqbd_pkg::OP_POP: begin
        if (empty_now) begin
          status_n = rqbd_pkg::ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
          head_n = head_inc;
        end
      end
      rqbd_pkg::OP_DROP: begin
        if (!empty_now) begin
          if (AW'(in_item.remove_count) > AW'(fill)) begin
            head_n = tail_e;
          end else begin
            head_n = head_add[CW-1:0];
          end
        end
      end
      default: ;
    endcase

    tail_n_inc = tail_n + CW'(1);
    if (tail_n_inc >= size) tail_n_inc = tail_n_inc - size;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[tail_e[IW-1:0]] <= in_item.push_value;
    end
    if (cmd.exec) begin
      rdata_r <= mem[head_e[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= rqbd_pkg::SLOTS_RESET;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (cmd.cfg_wr) begin
      slots_r <= cfg_word;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_n[IW-1:0];
      tail_r <= tail_n[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_n;
      pop_ok_r <= pop_ok;
      empty_r  <= (head_n == tail_n);
      full_r   <= (tail_n_inc == head_n);
    end
    if (cmd.load) begin
      out_r.status    <= status_r;
      out_r.pop_value <= pop_ok_r ? rdata_r : '0;
      out_r.is_empty  <= empty_r;
      out_r.is_full   <= full_r;
    end
  end

  assign out_item = out_r;

endmodule
